FILE: rtl/core/pzt_pkg.sv
package pzt_pkg;

  // fixed widths of the ports
  localparam int IN_COORD_W = 12;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int LINE_BOX_W = 48;
  localparam int VCOUNT_W   = 5;
  localparam int KIND_W     = 2;
  localparam int SIDE_W     = 3;

  // item opcodes
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // zone kinds
  localparam logic [KIND_W-1:0] KIND_LINE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE_ADV = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RECT     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POLY     = 2'd3;

  // side selections
  localparam logic [SIDE_W-1:0] SIDE_LEFT    = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT   = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_ABOVE   = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_BELOW   = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_INSIDE  = 3'd4;
  localparam logic [SIDE_W-1:0] SIDE_OUTSIDE = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_KIND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_SELECT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENT_VERT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BOX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd5;

  // work done by the shared multiplier pipe
  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_VLOAD,
    STEP_EDGE,
    STEP_LINE1,
    STEP_LINE2
  } step_e;

  typedef struct packed {
    logic  wr;
    logic  start;
    step_e step;
  } cmd_t;

endpackage

FILE: rtl/core/pzt_datapath.sv
module pzt_datapath #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pzt_pkg::cmd_t                        cmd_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]      rd_addr_i,
  input  logic [pzt_pkg::IDX_W-1:0]            vertex_index_i,
  input  logic [pzt_pkg::IN_COORD_W-1:0]       point_x_i,
  input  logic [pzt_pkg::IN_COORD_W-1:0]       point_y_i,
  input  logic                                 zone_enable_i,
  input  logic [pzt_pkg::KIND_W-1:0]           zone_kind_i,
  input  logic [pzt_pkg::SIDE_W-1:0]           side_select_i,
  input  logic                                 orientation_vertical_i,
  input  logic [pzt_pkg::LINE_BOX_W-1:0]       line_box_i,
  output logic                                 inside_o
);
  import pzt_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int PW  = (CB < IN_COORD_W) ? CB : IN_COORD_W;
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int XW  = (AW > IDX_W) ? AW : IDX_W;
  localparam int OW  = CB + 1;
  localparam int PRW = 2 * OW;
  localparam int DW  = PRW + 1;
  localparam int VW  = DW + 1;
  localparam int BXW = (4 * CB > LINE_BOX_W) ? 4 * CB : LINE_BOX_W;

  function automatic logic signed [OW-1:0] ext(input logic [CB-1:0] u);
    return {1'b0, u};
  endfunction

  logic [CB-1:0]     px_in, py_in;
  logic [CB-1:0]     px_q, py_q;
  logic [XW-1:0]     widx;
  logic              widx_ok;
  logic [2*CB-1:0]   mem_q [MAX_VERTICES];
  logic [2*CB-1:0]   rd_q;
  step_e             step1_q, step2_q;
  logic [CB-1:0]     ax, ay, bx, by;
  logic [CB-1:0]     bx_q, by_q;
  logic [BXW-1:0]    lb_ext;
  logic [CB-1:0]     x1, y1, x2, y2;
  logic signed [OW-1:0]  op1a, op1b, op2a, op2b;
  logic signed [PRW-1:0] prod1_q, prod2_q;
  logic              skip, onb, flip;
  logic              skip_q, onb_q, flip_q;
  logic signed [DW-1:0]  dd;
  logic signed [VW-1:0]  acc_q;
  logic              bnd_q, par_q;
  logic signed [OW-1:0]  dxs, dys, adx, ady;
  logic              in_rect, in_zone, side_ok;

  assign px_in  = CB'(point_x_i[PW-1:0]);
  assign py_in  = CB'(point_y_i[PW-1:0]);
  assign widx   = XW'(vertex_index_i);
  assign widx_ok = ({1'b0, widx} < (XW + 1)'(MAX_VERTICES));

  assign lb_ext = BXW'(line_box_i);
  assign x1 = lb_ext[0*CB +: CB];
  assign y1 = lb_ext[1*CB +: CB];
  assign x2 = lb_ext[2*CB +: CB];
  assign y2 = lb_ext[3*CB +: CB];

  // vertex table, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && widx_ok) begin
      mem_q[widx[AW-1:0]] <= {py_in, px_in};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // edge endpoints: a is the previous vertex, b the one just read
  assign ax = bx_q;
  assign ay = by_q;
  assign bx = rd_q[CB-1:0];
  assign by = rd_q[2*CB-1:CB];

  assign skip = (ay <= py_q && by <= py_q) || (ay > py_q && by > py_q) ||
                (ax < px_q && bx < px_q);
  assign onb  = (py_q == by) && ((px_q == bx) || ((py_q == ay) &&
                ((ax <= px_q && px_q <= bx) || (bx <= px_q && px_q <= ax))));
  assign flip = by < ay;

  always_comb begin
    op1a = '0;
    op1b = '0;
    op2a = '0;
    op2b = '0;
    case (step1_q)
      STEP_EDGE: begin
        op1a = ext(py_q) - ext(ay);
        op1b = ext(bx) - ext(ax);
        op2a = ext(px_q) - ext(ax);
        op2b = ext(by) - ext(ay);
      end
      STEP_LINE1: begin
        // A*x + B*y with B = -(x2-x1)
        op1a = ext(y2) - ext(y1);
        op1b = ext(px_q);
        op2a = ext(x2) - ext(x1);
        op2b = ext(py_q);
      end
      STEP_LINE2: begin
        op1a = ext(x2);
        op1b = ext(y1);
        op2a = ext(x1);
        op2b = ext(y2);
      end
      default: begin
      end
    endcase
  end

  assign dd = DW'(prod1_q) - DW'(prod2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step1_q <= STEP_IDLE;
      step2_q <= STEP_IDLE;
    end else begin
      step1_q <= cmd_i.step;
      step2_q <= step1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q  <= px_in;
      py_q  <= py_in;
      bnd_q <= 1'b0;
      par_q <= 1'b0;
      acc_q <= '0;
    end
    if (step1_q == STEP_VLOAD || step1_q == STEP_EDGE) begin
      bx_q <= bx;
      by_q <= by;
    end
    prod1_q <= PRW'(op1a) * PRW'(op1b);
    prod2_q <= PRW'(op2a) * PRW'(op2b);
    skip_q  <= skip;
    onb_q   <= onb;
    flip_q  <= flip;
    case (step2_q)
      STEP_EDGE: begin
        if (skip_q) begin
          if (onb_q) bnd_q <= 1'b1;
        end else if (dd == '0) begin
          bnd_q <= 1'b1;
        end else if (flip_q ? (dd < 0) : (dd > 0)) begin
          par_q <= ~par_q;
        end
      end
      STEP_LINE1: acc_q <= VW'(dd);
      STEP_LINE2: acc_q <= acc_q + VW'(dd);
      default: begin
      end
    endcase
  end

  assign dxs = ext(x2) - ext(x1);
  assign dys = ext(y2) - ext(y1);
  assign adx = (dxs < 0) ? -dxs : dxs;
  assign ady = (dys < 0) ? -dys : dys;

  assign in_rect = (x1 <= px_q) && (px_q < x2) && (y1 <= py_q) && (py_q < y2);

  always_comb begin
    in_zone = 1'b0;
    side_ok = 1'b0;
    case (zone_kind_i)
      KIND_LINE: begin
        if (orientation_vertical_i) begin
          if (side_select_i == SIDE_LEFT)  side_ok = px_q < x1;
          if (side_select_i == SIDE_RIGHT) side_ok = px_q > x1;
        end else begin
          if (side_select_i == SIDE_ABOVE) side_ok = py_q < x1;
          if (side_select_i == SIDE_BELOW) side_ok = py_q > x1;
        end
      end
      KIND_LINE_ADV: begin
        if (adx > ady) begin
          if (side_select_i == SIDE_ABOVE) side_ok = acc_q < 0;
          if (side_select_i == SIDE_BELOW) side_ok = acc_q > 0;
        end else begin
          if (side_select_i == SIDE_LEFT)  side_ok = acc_q > 0;
          if (side_select_i == SIDE_RIGHT) side_ok = acc_q < 0;
        end
      end
      default: begin
        in_zone = (zone_kind_i == KIND_RECT) ? in_rect : (bnd_q || par_q);
        if (side_select_i == SIDE_INSIDE)  side_ok = in_zone;
        if (side_select_i == SIDE_OUTSIDE) side_ok = !in_zone;
      end
    endcase
  end

  assign inside_o = zone_enable_i && side_ok;

endmodule

FILE: rtl/core/pzt_ctrl.sv
module pzt_ctrl #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic [pzt_pkg::KIND_W-1:0]        zone_kind_i,
  input  logic [pzt_pkg::VCOUNT_W-1:0]      vertex_count_i,
  input  logic                              inside_i,
  output pzt_pkg::cmd_t                     cmd_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              inside_zone_o
);
  import pzt_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int TW = $clog2(MAX_VERTICES + 1);
  localparam int SW = (TW > VCOUNT_W) ? TW : VCOUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POLY,
    S_LINE,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e        state_q;
  logic [TW-1:0] cnt_q;
  logic          drain_q;
  logic          out_valid_q;
  logic          inside_q;
  logic          accept;
  logic [SW-1:0] vc_ext;
  logic [TW-1:0] total;

  assign vc_ext = SW'(vertex_count_i);
  assign total  = (vc_ext > SW'(MAX_VERTICES)) ? TW'(MAX_VERTICES) : TW'(vc_ext);

  assign in_stall_o    = (state_q != S_IDLE);
  assign accept        = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign inside_zone_o = inside_q;

  always_comb begin
    cmd_o.wr    = accept && (opcode_i == OP_WRITE);
    cmd_o.start = accept && (opcode_i == OP_QUERY);
    cmd_o.step  = STEP_IDLE;
    rd_addr_o   = AW'(cnt_q - TW'(1));
    case (state_q)
      S_POLY: begin
        // first read fetches the closing vertex, then vertices in order
        if (cnt_q == '0) begin
          cmd_o.step = STEP_VLOAD;
          rd_addr_o  = AW'(total - TW'(1));
        end else begin
          cmd_o.step = STEP_EDGE;
        end
      end
      S_LINE: cmd_o.step = (cnt_q == '0) ? STEP_LINE1 : STEP_LINE2;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
    end else begin
      if (state_q == S_FINISH && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (cmd_o.start) begin
            if (zone_kind_i == KIND_POLY && total != '0) begin
              state_q <= S_POLY;
            end else if (zone_kind_i == KIND_LINE_ADV) begin
              state_q <= S_LINE;
            end else begin
              state_q <= S_FINISH;
            end
          end
        end
        S_POLY: begin
          if (cnt_q == total) begin
            state_q <= S_DRAIN;
            drain_q <= 1'b0;
          end else begin
            cnt_q <= cnt_q + TW'(1);
          end
        end
        S_LINE: begin
          if (cnt_q == TW'(1)) begin
            state_q <= S_DRAIN;
            drain_q <= 1'b0;
          end else begin
            cnt_q <= cnt_q + TW'(1);
          end
        end
        S_DRAIN: begin
          // let the read and multiply stages empty before finishing
          if (drain_q) state_q <= S_FINISH;
          drain_q <= 1'b1;
        end
        S_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            inside_q <= inside_i;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_poly_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POLY |-> cnt_q <= total)
    else $error("polygon edge counter ran past vertex count");

  a_drain_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN && drain_q) |=> state_q == S_FINISH)
    else $error("drain did not end in finish");

  a_finish_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !(out_valid_q && out_stall_i))
      |=> out_valid_q && state_q == S_IDLE)
    else $error("finished result not loaded into output register");

endmodule

FILE: rtl/core/point_in_zone_test.sv
// point in zone test: one query word gives one result word, a vertex write gives none
// input: next word taken once the result is in the output register; a polygon query
// stalls the input for one vertex table read per edge plus drain
// reset: async active low; clears control and config, but orientation resets to vertical;
// vertex table is undefined until written
module point_in_zone_test #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic [pzt_pkg::IDX_W-1:0]         vertex_index_i,
  input  logic [pzt_pkg::IN_COORD_W-1:0]    point_x_i,
  input  logic [pzt_pkg::IN_COORD_W-1:0]    point_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              inside_zone_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pzt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pzt_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import pzt_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  logic                  zone_enable_q;
  logic [KIND_W-1:0]     zone_kind_q;
  logic [SIDE_W-1:0]     side_select_q;
  logic                  orient_vert_q;
  logic [LINE_BOX_W-1:0] line_box_q;
  logic [VCOUNT_W-1:0]   vertex_count_q;
  cmd_t                  cmd;
  logic [AW-1:0]         rd_addr;
  logic                  inside_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_enable_q  <= 1'b0;
      zone_kind_q    <= '0;
      side_select_q  <= '0;
      orient_vert_q  <= 1'b1;
      line_box_q     <= '0;
      vertex_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ZONE_ENABLE:  zone_enable_q  <= cfg_data_i[0];
        REG_ZONE_KIND:    zone_kind_q    <= cfg_data_i[KIND_W-1:0];
        REG_SIDE_SELECT:  side_select_q  <= cfg_data_i[SIDE_W-1:0];
        REG_ORIENT_VERT:  orient_vert_q  <= cfg_data_i[0];
        REG_LINE_BOX:     line_box_q     <= cfg_data_i[LINE_BOX_W-1:0];
        REG_VERTEX_COUNT: vertex_count_q <= cfg_data_i[VCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pzt_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .zone_kind_i    (zone_kind_q),
    .vertex_count_i (vertex_count_q),
    .inside_i       (inside_res),
    .cmd_o          (cmd),
    .rd_addr_o      (rd_addr),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inside_zone_o  (inside_zone_o)
  );

  pzt_datapath #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .rd_addr_i              (rd_addr),
    .vertex_index_i         (vertex_index_i),
    .point_x_i              (point_x_i),
    .point_y_i              (point_y_i),
    .zone_enable_i          (zone_enable_q),
    .zone_kind_i            (zone_kind_q),
    .side_select_i          (side_select_q),
    .orientation_vertical_i (orient_vert_q),
    .line_box_i             (line_box_q),
    .inside_o               (inside_res)
  );

endmodule

FILE: tb/sv/point_in_zone_test_tb.sv
module point_in_zone_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pzt_pkg::*;

  localparam int MAX_V        = 16;
  localparam int COORD_MAX    = (1 << IN_COORD_W) - 1;
  localparam int SETTLE_WAIT  = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int IDLE_PCT     = 29;
  localparam int REPORT_LIMIT = 10;

  // side codes the block has no rule for
  localparam logic [SIDE_W-1:0] SIDE_SPARE = 3'd6;
  localparam logic [SIDE_W-1:0] SIDE_NONE  = 3'd7;

  typedef logic [IN_COORD_W-1:0] coord_t;

  typedef struct {
    coord_t px;
    coord_t py;
    bit     hit;
  } zone_answer_t;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic                  opcode       = OP_QUERY;
  logic [IDX_W-1:0]      vertex_index = '0;
  coord_t                point_x      = '0;
  coord_t                point_y      = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic                  inside_zone;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // copy of the zone setup as the block should hold it
  bit                    zone_en     = 1'b0;
  logic [KIND_W-1:0]     zone_kind   = KIND_LINE;
  logic [SIDE_W-1:0]     side_sel    = SIDE_LEFT;
  bit                    orient_vert = 1'b1;
  logic [LINE_BOX_W-1:0] box         = '0;
  logic [VCOUNT_W-1:0]   vcount      = '0;
  coord_t                vx [MAX_V];
  coord_t                vy [MAX_V];

  zone_answer_t answers_q[$];
  zone_answer_t head;
  int unsigned  mismatches = 0;
  bit           calm       = 1'b0;

  point_in_zone_test #(
    .MAX_VERTICES(MAX_V),
    .COORD_BITS  (IN_COORD_W)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .vertex_index_i(vertex_index),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .inside_zone_o (inside_zone),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // crossing parity: 1 inside, 0 on an edge or vertex, -1 outside
  function automatic int poly_where(longint px, longint py);
    int     n;
    int     crossings;
    longint ax, ay, bx, by, d;
    n = (vcount > MAX_V) ? MAX_V : int'(vcount);
    crossings = 0;
    if (n == 0) return -1;
    bx = vx[n-1];
    by = vy[n-1];
    for (int i = 0; i < n; i++) begin
      ax = bx;
      ay = by;
      bx = vx[i];
      by = vy[i];
      if ((ay <= py && by <= py) || (ay > py && by > py) || (ax < px && bx < px)) begin
        if (py == by && (px == bx || (py == ay &&
            ((ax <= px && px <= bx) || (bx <= px && px <= ax)))))
          return 0;
        continue;
      end
      d = (py - ay) * (bx - ax) - (px - ax) * (by - ay);
      if (d == 0) return 0;
      if (by < ay) d = -d;
      if (d > 0) crossings++;
    end
    return (crossings % 2 == 1) ? 1 : -1;
  endfunction

  function automatic bit zone_hit(coord_t x, coord_t y);
    longint px, py, x1, y1, x2, y2, v, dx, dy;
    bit     in_zone;
    px = x;
    py = y;
    x1 = box[IN_COORD_W-1:0];
    y1 = box[2*IN_COORD_W-1:IN_COORD_W];
    x2 = box[3*IN_COORD_W-1:2*IN_COORD_W];
    y2 = box[4*IN_COORD_W-1:3*IN_COORD_W];
    if (!zone_en) return 1'b0;
    case (zone_kind)
      KIND_LINE: begin
        if (orient_vert) begin
          if (side_sel == SIDE_LEFT) return px < x1;
          if (side_sel == SIDE_RIGHT) return px > x1;
        end else begin
          if (side_sel == SIDE_ABOVE) return py < x1;
          if (side_sel == SIDE_BELOW) return py > x1;
        end
        return 1'b0;
      end
      KIND_LINE_ADV: begin
        v  = (y2 - y1) * px + (x1 - x2) * py + (x2 * y1 - x1 * y2);
        dx = (x2 > x1) ? x2 - x1 : x1 - x2;
        dy = (y2 > y1) ? y2 - y1 : y1 - y2;
        if (dx > dy) begin
          if (side_sel == SIDE_ABOVE) return v < 0;
          if (side_sel == SIDE_BELOW) return v > 0;
        end else begin
          if (side_sel == SIDE_LEFT) return v > 0;
          if (side_sel == SIDE_RIGHT) return v < 0;
        end
        return 1'b0;
      end
      KIND_RECT: in_zone = (x1 <= px && px < x2 && y1 <= py && py < y2);
      default:   in_zone = (poly_where(px, py) >= 0);
    endcase
    if (side_sel == SIDE_INSIDE) return in_zone;
    if (side_sel == SIDE_OUTSIDE) return !in_zone;
    return 1'b0;
  endfunction

  function automatic coord_t pick_coord(int c, int span);
    int lo, hi;
    lo = (c - span < 0) ? 0 : c - span;
    hi = (c + span > COORD_MAX) ? COORD_MAX : c + span;
    if ($urandom_range(15) == 0) return $urandom_range(1) ? coord_t'(COORD_MAX) : coord_t'(0);
    return coord_t'($urandom_range(hi, lo));
  endfunction

  // one word into the block; valid stays high so back-to-back words need no extra edge
  task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                           input coord_t x, input coord_t y);
    zone_answer_t ans;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    vertex_index <= idx;
    point_x      <= x;
    point_y      <= y;
    do @(posedge clk); while (in_stall);
    if (op == OP_WRITE) begin
      vx[idx] = x;
      vy[idx] = y;
    end else begin
      ans.px    = x;
      ans.py    = y;
      ans.hit   = zone_hit(x, y);
      answers_q = {answers_q, ans};
    end
  endtask

  task automatic query(input coord_t x, input coord_t y);
    send_word(OP_QUERY, IDX_W'($urandom_range(MAX_V - 1)), x, y);
  endtask

  task automatic put_vertex(input int idx, input coord_t x, input coord_t y);
    send_word(OP_WRITE, IDX_W'(idx), x, y);
  endtask

  // block idle: no word pending, every answer back, vertex writes drained
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic set_zone(input bit en, input logic [KIND_W-1:0] kind,
                          input logic [SIDE_W-1:0] side, input bit vert,
                          input logic [LINE_BOX_W-1:0] lbox,
                          input logic [VCOUNT_W-1:0] cnt);
    logic [CFG_DATA_W-1:0] vals [6];
    settle();
    vals[REG_ZONE_ENABLE]  = CFG_DATA_W'(en);
    vals[REG_ZONE_KIND]    = CFG_DATA_W'(kind);
    vals[REG_SIDE_SELECT]  = CFG_DATA_W'(side);
    vals[REG_ORIENT_VERT]  = CFG_DATA_W'(vert);
    vals[REG_LINE_BOX]     = CFG_DATA_W'(lbox);
    vals[REG_VERTEX_COUNT] = CFG_DATA_W'(cnt);
    for (int r = 0; r < 6; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid   <= 1'b0;
    zone_en     = en;
    zone_kind   = kind;
    side_sel    = side;
    orient_vert = vert;
    box         = lbox;
    vcount      = cnt;
  endtask

  // every slot gets a vertex before any polygon reads the table
  task automatic fill_vertex_table();
    for (int i = 0; i < MAX_V; i++)
      put_vertex(i, coord_t'($urandom_range(COORD_MAX)), coord_t'($urandom_range(COORD_MAX)));
  endtask

  task automatic test_reset_defaults();
    query(coord_t'(0), coord_t'(0));
    query(coord_t'(COORD_MAX), coord_t'(COORD_MAX));
  endtask

  task automatic test_divider_line();
    set_zone(1'b1, KIND_LINE, SIDE_LEFT, 1'b1, {36'd0, 12'd2048}, '0);
    query(12'd2047, 12'd0);
    query(12'd2048, 12'd4095);
    set_zone(1'b1, KIND_LINE, SIDE_RIGHT, 1'b1, {36'd0, 12'd2048}, '0);
    query(12'd2049, 12'd7);
    query(12'd0, 12'd3000);
    set_zone(1'b1, KIND_LINE, SIDE_ABOVE, 1'b0, {36'd0, 12'd2048}, '0);
    query(12'd5, 12'd2047);
    set_zone(1'b1, KIND_LINE, SIDE_BELOW, 1'b0, {36'd0, 12'd2048}, '0);
    query(12'd5, 12'd4095);
    // side rule that does not fit the orientation
    set_zone(1'b1, KIND_LINE, SIDE_ABOVE, 1'b1, {36'd0, 12'd2048}, '0);
    query(12'd0, 12'd0);
    set_zone(1'b1, KIND_LINE, SIDE_NONE, 1'b1, '1, '0);
    query(12'd0, 12'd0);
  endtask

  task automatic test_general_line();
    // steep line, sign picks left or right
    set_zone(1'b1, KIND_LINE_ADV, SIDE_LEFT, 1'b0, {12'd4095, 12'd200, 12'd0, 12'd100}, '0);
    query(12'd0, 12'd2000);
    query(12'd100, 12'd0);
    set_zone(1'b1, KIND_LINE_ADV, SIDE_RIGHT, 1'b1, {12'd4095, 12'd200, 12'd0, 12'd100}, '0);
    query(12'd4095, 12'd2000);
    // flat line, sign picks above or below
    set_zone(1'b1, KIND_LINE_ADV, SIDE_BELOW, 1'b0, {12'd300, 12'd4095, 12'd100, 12'd0}, '0);
    query(12'd2000, 12'd4095);
    set_zone(1'b1, KIND_LINE_ADV, SIDE_ABOVE, 1'b0, {12'd300, 12'd4095, 12'd100, 12'd0}, '0);
    query(12'd2000, 12'd0);
    set_zone(1'b1, KIND_LINE_ADV, SIDE_INSIDE, 1'b0, {12'd300, 12'd4095, 12'd100, 12'd0}, '0);
    query(12'd2000, 12'd0);
  endtask

  task automatic test_rectangle();
    set_zone(1'b1, KIND_RECT, SIDE_INSIDE, 1'b0, {12'd200, 12'd200, 12'd100, 12'd100}, '0);
    query(12'd100, 12'd100);
    query(12'd199, 12'd199);
    query(12'd200, 12'd150);
    set_zone(1'b1, KIND_RECT, SIDE_OUTSIDE, 1'b0, {12'd200, 12'd200, 12'd100, 12'd100}, '0);
    query(12'd50, 12'd50);
    // corners swapped, nothing can be inside
    set_zone(1'b1, KIND_RECT, SIDE_INSIDE, 1'b0, {12'd200, 12'd100, 12'd100, 12'd200}, '0);
    query(12'd150, 12'd150);
  endtask

  task automatic test_polygon();
    put_vertex(0, 12'd1000, 12'd1000);
    put_vertex(1, 12'd2000, 12'd1000);
    put_vertex(2, 12'd2000, 12'd2000);
    put_vertex(3, 12'd1000, 12'd2000);
    set_zone(1'b1, KIND_POLY, SIDE_INSIDE, 1'b0, '0, 5'd4);
    query(12'd1500, 12'd1500);
    query(12'd2000, 12'd1500);
    query(12'd1000, 12'd1000);
    query(12'd2500, 12'd1500);
    set_zone(1'b1, KIND_POLY, SIDE_OUTSIDE, 1'b0, '0, 5'd4);
    query(12'd500, 12'd500);
    set_zone(1'b1, KIND_POLY, SIDE_INSIDE, 1'b0, '0, 5'd0);
    query(12'd1500, 12'd1500);
    // count beyond the table clips to the full table
    set_zone(1'b1, KIND_POLY, SIDE_OUTSIDE, 1'b0, '0, 5'd31);
    query(12'd1500, 12'd1500);
    set_zone(1'b0, KIND_POLY, SIDE_INSIDE, 1'b0, '0, 5'd4);
    query(12'd1500, 12'd1500);
  endtask

  task automatic test_random_zones();
    bit                    en, vert;
    logic [KIND_W-1:0]     kind;
    logic [SIDE_W-1:0]     side;
    coord_t                c [4];
    coord_t                t, qx, qy;
    logic [LINE_BOX_W-1:0] lbox;
    logic [VCOUNT_W-1:0]   cnt;
    int                    cx, cy, span, items, nsat, j, j2, r;
    for (int ph = 0; ph < 32; ph++) begin
      cx = $urandom_range(COORD_MAX);
      cy = $urandom_range(COORD_MAX);
      case ($urandom_range(2))
        0:       span = 15;
        1:       span = 300;
        default: span = COORD_MAX;
      endcase
      en   = ($urandom_range(9) != 0);
      kind = KIND_W'($urandom_range(3));
      vert = $urandom_range(1);
      if ($urandom_range(4) == 0) begin
        side = SIDE_W'($urandom_range(7));
      end else begin
        case (kind)
          KIND_LINE: begin
            if (vert) side = $urandom_range(1) ? SIDE_LEFT : SIDE_RIGHT;
            else side = $urandom_range(1) ? SIDE_ABOVE : SIDE_BELOW;
          end
          KIND_LINE_ADV: side = SIDE_LEFT + SIDE_W'($urandom_range(3));
          default: side = $urandom_range(1) ? SIDE_INSIDE : SIDE_OUTSIDE;
        endcase
      end
      for (int f = 0; f < 4; f++) c[f] = pick_coord((f % 2 == 1) ? cy : cx, span);
      if (kind == KIND_RECT && $urandom_range(3) != 0) begin
        if (c[0] > c[2]) begin
          t = c[0]; c[0] = c[2]; c[2] = t;
        end
        if (c[1] > c[3]) begin
          t = c[1]; c[1] = c[3]; c[3] = t;
        end
      end
      lbox = {c[3], c[2], c[1], c[0]};
      case ($urandom_range(15))
        0:       lbox = '0;
        1:       lbox = '1;
        default: ;
      endcase
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(2))
          0:       cnt = 5'd0;
          1:       cnt = 5'd17;
          default: cnt = 5'd31;
        endcase
      end else begin
        cnt = VCOUNT_W'($urandom_range(MAX_V, 3));
      end
      if (ph == 5) side = SIDE_SPARE;
      set_zone(en, kind, side, vert, lbox, cnt);
      calm = (ph == 9);
      nsat = (cnt > MAX_V) ? MAX_V : int'(cnt);
      if (kind == KIND_POLY)
        for (int k = 0; k < nsat; k++) put_vertex(k, pick_coord(cx, span), pick_coord(cy, span));
      items = calm ? 150 : 40;
      for (int k = 0; k < items; k++) begin
        r = $urandom_range(19);
        if (r == 0) begin
          put_vertex($urandom_range(MAX_V - 1), pick_coord(cx, span), pick_coord(cy, span));
        end else begin
          if (r < 5 && kind == KIND_POLY && nsat > 0) begin
            // land on a vertex, or on an edge midpoint when it falls on the grid
            j  = $urandom_range(nsat - 1);
            j2 = (j + 1) % nsat;
            qx = vx[j];
            qy = vy[j];
            if (r >= 3) begin
              qx = coord_t'((int'(vx[j]) + int'(vx[j2])) / 2);
              qy = coord_t'((int'(vy[j]) + int'(vy[j2])) / 2);
            end
          end else if (r < 7) begin
            qx = $urandom_range(1) ? c[0] : c[2];
            qy = $urandom_range(1) ? c[1] : c[3];
            if (lbox == '0 || lbox == '1) begin
              qx = lbox[IN_COORD_W-1:0];
              qy = lbox[2*IN_COORD_W-1:IN_COORD_W];
            end
          end else begin
            qx = pick_coord(cx, span);
            qy = pick_coord(cy, span);
          end
          query(qx, qy);
        end
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (answers_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: inside_zone word %0b arrived with no query waiting", $time, inside_zone);
      end else begin
        head = answers_q.pop_front();
        if (inside_zone !== head.hit) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: point (%0d,%0d) inside_zone expected %0b got %0b",
                     $time, head.px, head.py, head.hit, inside_zone);
        end
      end
    end
  end

  initial begin
    for (int unsigned n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fill_vertex_table();
    test_reset_defaults();
    test_divider_line();
    test_general_line();
    test_rectangle();
    test_polygon();
    test_random_zones();
    settle();
    if (mismatches == 0 && answers_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: point_in_zone_test.f
rtl/core/pzt_pkg.sv
rtl/core/pzt_datapath.sv
rtl/core/pzt_ctrl.sv
rtl/core/point_in_zone_test.sv
tb/sv/point_in_zone_test_tb.sv
